// ===== hw/rtl/scc_pkg.sv =====
// Straddling checkerboard cipher: shared types, codes and constants.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package scc_pkg;

  localparam int TABLE_DEPTH  = 30;
  localparam int POS_W        = 5;
  localparam int SYM_W        = 8;
  localparam int DIGIT_W      = 4;
  localparam int CFG_IDX_W    = 1;
  localparam int ROW_WIDTH    = 10;
  localparam int ROW_ONE_BASE = 10;
  localparam int ROW_TWO_BASE = 20;

  localparam logic [SYM_W-1:0] ASCII_ZERO = 8'h30;
  localparam logic [SYM_W-1:0] ASCII_NINE = 8'h39;

  typedef enum logic [1:0] {
    OP_LOAD   = 2'd0,
    OP_ENCODE = 2'd1,
    OP_DECODE = 2'd2,
    OP_NONE   = 2'd3
  } scc_op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PREFIX_ONE = 1'b0,
    CFG_PREFIX_TWO = 1'b1
  } scc_cfg_t;

  typedef enum logic [1:0] {
    ROW_TOP = 2'd0,
    ROW_ONE = 2'd1,
    ROW_TWO = 2'd2
  } scc_row_t;

  typedef enum logic [2:0] {
    KIND_NONE   = 3'd0,
    KIND_LOAD   = 3'd1,
    KIND_ENCODE = 3'd2,
    KIND_DECODE = 3'd3,
    KIND_ERROR  = 3'd4
  } scc_kind_t;

  typedef struct packed {
    logic [1:0]       operation;
    logic [POS_W-1:0] entry_index;
    logic [SYM_W-1:0] symbol;
  } scc_in_t;

  typedef struct packed {
    logic [SYM_W-1:0] out_symbol;
    logic             last;
    logic             error;
  } scc_out_t;

  // Record carried down the cell chain.
  typedef struct packed {
    logic             valid;
    scc_kind_t        kind;
    logic [SYM_W-1:0] symbol;
    logic [POS_W-1:0] pos;
    logic             found;
  } scc_item_t;

endpackage

`default_nettype wire

// ===== hw/rtl/scc_front.sv =====
// Chain head: classifies commands and tracks the pending decode row.
// Depends on scc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module scc_front
  import scc_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 accept,
  input  logic                 cmd_valid,
  input  scc_in_t              cmd,
  input  logic [DIGIT_W-1:0]   prefix_one,
  input  logic [DIGIT_W-1:0]   prefix_two,
  output scc_item_t            item
);

  scc_row_t             pending_row;
  scc_row_t             pending_row_next;
  logic                 is_digit;
  logic [DIGIT_W-1:0]   digit;
  logic [POS_W-1:0]     row_base;
  logic [POS_W-1:0]     dec_pos;

  assign is_digit = (cmd.symbol >= ASCII_ZERO) && (cmd.symbol <= ASCII_NINE);
  assign digit    = DIGIT_W'(cmd.symbol - ASCII_ZERO);
  assign dec_pos  = row_base + POS_W'(digit);

  always_comb begin
    case (pending_row)
      ROW_ONE: row_base = POS_W'(ROW_ONE_BASE);
      ROW_TWO: row_base = POS_W'(ROW_TWO_BASE);
      default: row_base = '0;
    endcase
  end

  always_comb begin
    item.valid       = cmd_valid;
    item.kind        = KIND_NONE;
    item.symbol      = cmd.symbol;
    item.pos         = cmd.entry_index;
    item.found       = 1'b0;
    pending_row_next = pending_row;
    unique case (scc_op_t'(cmd.operation))
      OP_LOAD: begin
        if (cmd.entry_index < POS_W'(TABLE_DEPTH)) begin
          item.kind = KIND_LOAD;
        end
      end
      OP_ENCODE: begin
        item.kind = KIND_ENCODE;
      end
      OP_DECODE: begin
        if (!is_digit) begin
          item.kind        = KIND_ERROR;
          pending_row_next = ROW_TOP;
        end else if (pending_row == ROW_TOP && digit == prefix_one) begin
          pending_row_next = ROW_ONE;
        end else if (pending_row == ROW_TOP && digit == prefix_two) begin
          pending_row_next = ROW_TWO;
        end else begin
          pending_row_next = ROW_TOP;
          item.pos         = dec_pos;
          item.kind        = (dec_pos < POS_W'(TABLE_DEPTH)) ? KIND_DECODE : KIND_ERROR;
        end
      end
      default: begin
        item.kind = KIND_NONE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pending_row <= ROW_TOP;
    end else if (accept) begin
      pending_row <= pending_row_next;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/scc_cell.sv =====
// One table cell: holds one character and processes the record passing through.
// Depends on scc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module scc_cell
  import scc_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              adv,
  input  logic [POS_W-1:0]  cell_index,
  input  scc_item_t         up,
  output scc_item_t         down
);

  logic [SYM_W-1:0] entry;
  logic             written;
  logic             valid;
  logic             load_hit;
  scc_item_t        stage;
  scc_item_t        stage_next;

  assign load_hit = adv && up.valid && up.kind == KIND_LOAD && up.pos == cell_index;

  always_comb begin
    stage_next = up;
    if (up.kind == KIND_ENCODE && !up.found && written && entry == up.symbol) begin
      stage_next.found = 1'b1;
      stage_next.pos   = cell_index;
    end
    if (up.kind == KIND_DECODE && up.pos == cell_index) begin
      stage_next.symbol = entry;
    end
  end

  always_comb begin
    down       = stage;
    down.valid = valid;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (adv) begin
      valid <= up.valid;
    end
  end

  // only loaded entries take part in the encode search
  always_ff @(posedge clk) begin
    if (rst) begin
      written <= 1'b0;
    end else if (load_hit) begin
      written <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      stage <= stage_next;
    end
  end

  always_ff @(posedge clk) begin
    if (load_hit) begin
      entry <= up.symbol;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/scc_emit.sv =====
// Result stage: turns encode, decode and error records into one or two transfers.
// Depends on scc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module scc_emit
  import scc_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  scc_item_t           tail,
  input  logic [DIGIT_W-1:0]  prefix_one,
  input  logic [DIGIT_W-1:0]  prefix_two,
  input  logic                res_stall,
  output logic                res_valid,
  output scc_out_t            res,
  output logic                free
);

  logic             sec_valid;
  logic [SYM_W-1:0] sec_symbol;
  logic             take;
  logic             two;
  logic             shift_second;
  logic             load_new;
  scc_out_t         first;
  logic [POS_W-1:0] col_wide;
  logic [SYM_W-1:0] col_symbol;

  assign take = tail.valid && (tail.kind == KIND_ENCODE || tail.kind == KIND_DECODE ||
                               tail.kind == KIND_ERROR);
  assign free         = !res_valid || (!res_stall && !sec_valid);
  assign shift_second = res_valid && !res_stall && sec_valid;
  assign load_new     = free && take;

  always_comb begin
    if (tail.pos < POS_W'(ROW_ONE_BASE)) begin
      col_wide = tail.pos;
    end else if (tail.pos < POS_W'(ROW_TWO_BASE)) begin
      col_wide = tail.pos - POS_W'(ROW_WIDTH);
    end else begin
      col_wide = tail.pos - POS_W'(ROW_TWO_BASE);
    end
    col_symbol = ASCII_ZERO + SYM_W'(col_wide);
  end

  always_comb begin
    first.out_symbol = '0;
    first.last       = 1'b1;
    first.error      = 1'b1;
    two              = 1'b0;
    case (tail.kind)
      KIND_DECODE: begin
        first.out_symbol = tail.symbol;
        first.error      = 1'b0;
      end
      KIND_ENCODE: begin
        if (tail.found) begin
          first.error = 1'b0;
          if (tail.pos < POS_W'(ROW_ONE_BASE)) begin
            first.out_symbol = col_symbol;
          end else begin
            first.last       = 1'b0;
            two              = 1'b1;
            first.out_symbol = (tail.pos < POS_W'(ROW_TWO_BASE))
                               ? ASCII_ZERO + SYM_W'(prefix_one)
                               : ASCII_ZERO + SYM_W'(prefix_two);
          end
        end
      end
      default: begin
        first.out_symbol = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
      sec_valid <= 1'b0;
    end else if (shift_second) begin
      sec_valid <= 1'b0;
    end else if (free) begin
      res_valid <= take;
      sec_valid <= load_new && two;
    end
  end

  always_ff @(posedge clk) begin
    if (shift_second) begin
      res.out_symbol <= sec_symbol;
      res.last       <= 1'b1;
      res.error      <= 1'b0;
    end else if (load_new) begin
      res        <= first;
      sec_symbol <= col_symbol;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/straddling_checkerboard_cipher_core.sv =====
// Straddling checkerboard cipher core: head, chain of table cells, result stage.
// Depends on scc_pkg, scc_front, scc_cell and scc_emit.
//
// channel  signals                                   transfer when
// cmd      cmd_valid, cmd_stall, cmd (scc_in_t)       cmd_valid && !cmd_stall
// res      res_valid, res_stall, res (scc_out_t)      res_valid && !res_stall
// cfg      cfg_valid, cfg_ready, cfg_index, cfg_data  cfg_valid && cfg_ready
//
// Each command passes through TABLE_DEPTH registered cells, then the registered result
// stage. One command enters per cycle while the chain advances; an encode that gives
// two digits holds the chain while its second digit waits to be sent.
// Reset clears the chain, the pending row and sets the prefixes to 0 and 1; the table
// holds nothing defined until loaded. A stalled result freezes the whole chain.
`timescale 1ns / 1ps
`default_nettype none

module straddling_checkerboard_cipher_core
  import scc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cmd_valid,
  output logic                  cmd_stall,
  input  scc_in_t               cmd,
  output logic                  res_valid,
  input  logic                  res_stall,
  output scc_out_t              res,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [DIGIT_W-1:0]    cfg_data
);

  logic [DIGIT_W-1:0] prefix_one;
  logic [DIGIT_W-1:0] prefix_two;
  logic               adv;
  scc_item_t          link [TABLE_DEPTH+1];

  assign cfg_ready = 1'b1;
  assign cmd_stall = !adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      prefix_one <= DIGIT_W'(0);
      prefix_two <= DIGIT_W'(1);
    end else if (cfg_valid && cfg_ready) begin
      unique case (scc_cfg_t'(cfg_index))
        CFG_PREFIX_ONE: prefix_one <= cfg_data;
        CFG_PREFIX_TWO: prefix_two <= cfg_data;
      endcase
    end
  end

  scc_front u_front (
    .clk        (clk),
    .rst        (rst),
    .accept     (cmd_valid && adv),
    .cmd_valid  (cmd_valid),
    .cmd        (cmd),
    .prefix_one (prefix_one),
    .prefix_two (prefix_two),
    .item       (link[0])
  );

  for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
    scc_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .adv        (adv),
      .cell_index (POS_W'(g)),
      .up         (link[g]),
      .down       (link[g+1])
    );
  end

  scc_emit u_emit (
    .clk        (clk),
    .rst        (rst),
    .tail       (link[TABLE_DEPTH]),
    .prefix_one (prefix_one),
    .prefix_two (prefix_two),
    .res_stall  (res_stall),
    .res_valid  (res_valid),
    .res        (res),
    .free       (adv)
  );

  a_second_digit_follows: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !res_stall && !res.last) |=> res_valid)
    else $error("column digit missing after prefix digit");

  a_prefix_not_error: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !res.last) |-> (!res.error && res.out_symbol >= ASCII_ZERO))
    else $error("non-final result flagged as error");

  a_chain_frozen: assert property (@(posedge clk) disable iff (rst)
    !adv |=> $stable(link[TABLE_DEPTH].valid))
    else $error("chain moved while result stage busy");

endmodule

`default_nettype wire
